>>> hdl/shelf_partition_min_cost_dp_macros.svh
// Assertion macros for the shelf partition block
`ifndef SHELF_PARTITION_MIN_COST_DP_MACROS_SVH
`define SHELF_PARTITION_MIN_COST_DP_MACROS_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPD_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SPD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> hdl/spd_pkg.sv
`default_nettype none
package spd_pkg;
   localparam int DimW  = 20;
   localparam int LimW  = 30;
   localparam int CostW = 31;
   localparam int SumW  = 31;
   localparam int AccW  = 32;
   localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RD,
      ST_CHK,
      ST_DONE,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

>>> hdl/spd_scan_unit.sv
`default_nettype none
// Shared compare/add unit: one backward cut point evaluated per use.
module spd_scan_unit (
   input  wire logic [spd_pkg::SumW-1:0]  sum_i,
   input  wire logic [spd_pkg::SumW-1:0]  sum_k,
   input  wire logic [spd_pkg::LimW-1:0]  limit,
   input  wire logic [spd_pkg::DimW-1:0]  dim_j,
   input  wire logic [spd_pkg::DimW-1:0]  run_max,
   input  wire logic [spd_pkg::CostW-1:0] cost_k,
   input  wire logic [spd_pkg::AccW-1:0]  best,
   output logic                           over,
   output logic [spd_pkg::DimW-1:0]       new_max,
   output logic [spd_pkg::AccW-1:0]       new_best
);
   import spd_pkg::*;
   logic [AccW-1:0] cand;
   always_comb begin
      over    = (sum_i - sum_k) > {1'b0, limit};
      new_max = (dim_j > run_max) ? dim_j : run_max;
      cand    = {1'b0, cost_k} + {{(AccW-DimW){1'b0}}, new_max};
      new_best = (cand < best) ? cand : best;
   end
endmodule
`default_nettype wire

>>> hdl/shelf_partition_min_cost_dp.sv
// Per book the FSM steps through PREP, RD, a CHK step for each cut point scanned
// (scan stops at the shelf limit or the sequence start), DONE and OUT.
// Throughput: one book at a time; the backward scan through the history
// memories with one compare/add unit sets the rate.
// Reset clears the book count and sets shelf_limit to its maximum.
`default_nettype none
`include "shelf_partition_min_cost_dp_macros.svh"
module shelf_partition_min_cost_dp #(
   parameter int MAX_BOOKS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire logic [spd_pkg::LimW-1:0]    csr_shelf_limit,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_start_new,
   input  wire logic [spd_pkg::DimW-1:0]    req_max_dim,
   input  wire logic [spd_pkg::DimW-1:0]    req_sum_dim,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [spd_pkg::CostW-1:0]        rsp_best_cost,
   output logic                             rsp_full_error
);
   import spd_pkg::*;
   localparam int AW = $clog2(MAX_BOOKS + 1);
   localparam int Depth = MAX_BOOKS + 1;
   localparam logic [AW-1:0] MaxCnt = AW'(MAX_BOOKS);

   // history memories, index 0 = empty prefix
   logic [SumW-1:0]  sum_mem  [Depth];
   logic [DimW-1:0]  dim_mem  [Depth];
   logic [CostW-1:0] cost_mem [Depth];

   state_type       state_ff, state_in;
   logic [LimW-1:0] limit_ff;
   logic [AW-1:0]   count_ff, count_in;
   logic [AW-1:0]   j_ff, j_in;
   logic [DimW-1:0] w_ff, h_ff;
   logic            start_ff;
   logic [SumW-1:0] sum_i_ff, sum_i_in;
   logic [DimW-1:0] max_ff, max_in;
   logic [AccW-1:0] best_ff, best_in;
   logic [CostW-1:0] out_cost_ff, out_cost_in;
   logic             out_err_ff, out_err_in;
   logic [SumW-1:0]  rd_sum_k;
   logic [DimW-1:0]  rd_dim_j;
   logic [CostW-1:0] rd_cost_k;
   logic [AW-1:0]    rd_addr_k, rd_addr_j;
   logic             wr_en;
   logic             over;
   logic [DimW-1:0]  new_max;
   logic [AccW-1:0]  new_best;
   logic [AW-1:0]    base;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_best_cost  = out_cost_ff;
   assign rsp_full_error = out_err_ff;
   assign base           = start_ff ? '0 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= {LimW{1'b1}};
      else if (csr_write) limit_ff <= csr_shelf_limit;
   end

   // memory reads: k = j-1 for sum/cost, j for dim
   always_ff @(posedge clock) begin
      rd_sum_k  <= (rd_addr_k == '0) ? '0 : sum_mem[rd_addr_k];
      rd_cost_k <= (rd_addr_k == '0) ? '0 : cost_mem[rd_addr_k];
      rd_dim_j  <= dim_mem[rd_addr_j];
      if (wr_en) begin
         sum_mem[j_ff]  <= sum_i_ff;
         dim_mem[j_ff]  <= w_ff;
         cost_mem[j_ff] <= (best_ff > {1'b0, CostMax}) ? CostMax : best_ff[CostW-1:0];
      end
   end

   spd_scan_unit u_scan (
      .sum_i(sum_i_ff), .sum_k(rd_sum_k), .limit(limit_ff), .dim_j(rd_dim_j),
      .run_max(max_ff), .cost_k(rd_cost_k), .best(best_ff),
      .over(over), .new_max(new_max), .new_best(new_best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      j_ff        <= j_in;
      sum_i_ff    <= sum_i_in;
      max_ff      <= max_in;
      best_ff     <= best_in;
      out_cost_ff <= out_cost_in;
      out_err_ff  <= out_err_in;
      if (req_valid && !req_stall) begin
         w_ff     <= req_max_dim;
         h_ff     <= req_sum_dim;
         start_ff <= req_start_new;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      j_in        = j_ff;
      sum_i_in    = sum_i_ff;
      max_in      = max_ff;
      best_in     = best_ff;
      out_cost_in = out_cost_ff;
      out_err_in  = out_err_ff;
      rd_addr_k   = j_ff - AW'(1);
      rd_addr_j   = j_ff;
      wr_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            // read prefix entry of the previous book (j = base)
            if (start_ff) count_in = '0;
            rd_addr_k = base;
            j_in      = base;
            state_in  = ST_RD;
         end
         ST_RD: begin
            if (base >= MaxCnt) begin
               rd_addr_k   = base;
               state_in    = ST_DONE;
               out_err_in  = 1'b1;
            end else begin
               sum_i_in   = rd_sum_k + {{(SumW-DimW){1'b0}}, h_ff};
               max_in     = w_ff;
               best_in    = {1'b0, rd_cost_k} + {{(AccW-DimW){1'b0}}, w_ff};
               out_err_in = 1'b0;
               // now scan j = base down to 1; prefetch j=base
               rd_addr_k  = j_ff - AW'(1);
               state_in   = (j_ff == '0) ? ST_DONE : ST_CHK;
            end
         end
         ST_CHK: begin
            if (over) begin
               state_in = ST_DONE;
            end else begin
               max_in  = new_max;
               best_in = new_best;
               if (j_ff == AW'(1)) state_in = ST_DONE;
               else begin
                  j_in      = j_ff - AW'(1);
                  rd_addr_k = j_ff - AW'(2);
                  rd_addr_j = j_ff - AW'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_err_ff) begin
               out_cost_in = rd_cost_k;
            end else begin
               j_in        = base + AW'(1);
               out_cost_in = (best_ff > {1'b0, CostMax}) ? CostMax : best_ff[CostW-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (j_ff == base + AW'(1) && !out_err_ff && count_ff == base) begin
               wr_en    = 1'b1;
               count_in = j_ff;
            end
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SPD_ASSERT_IMPL(a_cnt_cap, clock, reset, count_ff <= MaxCnt, "book count beyond capacity")
   `SPD_ASSERT_IMPL(a_busy, clock, reset, rsp_valid |-> req_stall, "result shown while idle")
   `SPD_ASSERT_IMPL(a_err_cnt, clock, reset, (rsp_valid && rsp_full_error) |-> (count_ff == MaxCnt), "error without full history")
   `SPD_ASSERT_NORST(a_rst, clock, reset |=> (state_ff == ST_IDLE), "not idle after reset")
endmodule
`default_nettype wire
